### sv/rar_pkg.sv
// rar_pkg: shared constants, types and status codes for rational_arith_reduce
// no dependencies
package rar_pkg;
  localparam int OPW = 16;               // operand width
  localparam int MW  = 2 * OPW + 1;      // magnitude width of raw results
  localparam int CW  = $clog2(MW + 1);   // bit counter width

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERODEN = 2'd1;
  localparam logic [1:0] ST_DIVZERO = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [OPW-1:0] a_num;
    logic signed [OPW-1:0] a_den;
    logic signed [OPW-1:0] b_num;
    logic signed [OPW-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture operands, form magnitudes
    logic mul;     // form products
    logic comb;    // form raw num and den, seed gcd operands
    logic mstart;  // start x mod y
    logic step;    // one shift-subtract bit
    logic gnext;   // x, y <- y, x mod y
    logic dstart;  // start dividing num by gcd
    logic dnext;   // switch from num to den division
    logic fin;     // form result word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;       // input error found at load
    logic num_zero;  // raw numerator zero
    logic y_zero;    // gcd remainder zero
    logic cnt_zero;  // shift-subtract unit finished
  } sts_t;
endpackage

### sv/rar_if.sv
// rar_if: valid/ready channel carrying one word
// depends on nothing; payload type is a parameter
interface rar_if #(parameter type word_t = logic) (input logic clk);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/rational_arith_reduce.sv
// rational_arith_reduce: fraction add/sub/mul/div with gcd reduction
// depends on rar_pkg, rar_if, rar_dp, rar_ctrl
//
// usage:
//   in:  one word per operation: opcode and two fractions a_num/a_den, b_num/b_den
//   out: one word per input: reduced res_num (signed), res_den (positive), status
//   status 1 marks a zero input denominator, status 2 a division by a zero fraction;
//   both give 0/0. a zero result is given as 0/1.
// sequence and throughput:
//   one word at a time. after the input is taken come multiply, combine and check,
//   then the gcd loop runs one or more euclid steps (each a 33-bit bit-serial
//   modulo plus setup and swap) on the shared shift-subtract unit, then two
//   restoring divisions reduce num and den. errors and zero results skip the gcd
//   loop and the divisions. the next input is taken at the earliest in the cycle
//   after the result is taken.
// reset:
//   rst (synchronous) returns the sequencer to idle, no result pending.
// stall:
//   a finished result is held on out until taken; in stays not ready meanwhile.
module rational_arith_reduce import rar_pkg::*; (
  input logic clk,
  input logic rst,
  rar_if.sink   in,
  rar_if.source out
);
  cmd_t cmd;
  sts_t sts;
  out_word_t dout;

  rar_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .sts(sts), .cmd(cmd)
  );
  rar_dp u_dp (.clk(clk), .din(in.data), .cmd(cmd), .sts(sts), .dout(dout));

  // result word held in datapath output register
  assign out.data = dout;
endmodule

### sv/rar_dp.sv
// rar_dp: datapath; products, signed sum, bit-serial gcd modulo and division
// depends on rar_pkg
module rar_dp import rar_pkg::*; (
  input  logic      clk,
  input  in_word_t  din,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t dout
);
  logic [1:0]     op;
  logic           an_neg, bn_neg, neg, err_z, err_d;
  logic [OPW:0]   anm, adm, bnm, bdm;
  logic [MW-1:0]  p1, p2, p3;
  logic [MW-1:0]  num, den, x, y;
  logic [MW-1:0]  rem, quo, dvd, qn;
  logic [CW-1:0]  cnt;
  logic           phase; // 0 modulo for gcd, 1 division by gcd
  logic [MW:0]    trial;
  logic [MW-1:0]  divisor;
  logic           n2, sum_neg, neg_c;
  logic [MW-1:0]  m1, m2, sum_mag, num_c, den_c;

  function automatic logic [OPW:0] mag(input logic [OPW-1:0] v);
    logic [OPW:0] e;
    e = {v[OPW-1], v};
    return e[OPW] ? (~e + 1'b1) : e;
  endfunction

  assign divisor = phase ? x : y;
  assign trial   = {rem, dvd[MW-1]} - {1'b0, divisor};

  always_comb begin
    n2 = (op == OP_SUB) ? !bn_neg : bn_neg;
    m1 = (adm == bdm) ? MW'(anm) : p1;
    m2 = (adm == bdm) ? MW'(bnm) : p2;
    if (an_neg == n2) begin
      sum_neg = an_neg; sum_mag = m1 + m2;
    end else if (m1 >= m2) begin
      sum_neg = an_neg; sum_mag = m1 - m2;
    end else begin
      sum_neg = n2; sum_mag = m2 - m1;
    end
    case (op)
      OP_MUL, OP_DIV: begin
        neg_c = an_neg != bn_neg; num_c = p1; den_c = p3;
      end
      default: begin
        neg_c = sum_neg; num_c = sum_mag; den_c = (adm == bdm) ? MW'(adm) : p3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= din.opcode;
      err_z  <= (din.a_den == '0) || (din.b_den == '0);
      err_d  <= (din.opcode == OP_DIV) && (din.b_num == '0);
      an_neg <= din.a_num[OPW-1] != din.a_den[OPW-1] && din.a_num != '0;
      bn_neg <= din.b_num[OPW-1] != din.b_den[OPW-1] && din.b_num != '0;
      anm <= mag(din.a_num);
      adm <= mag(din.a_den);
      bnm <= mag(din.b_num);
      bdm <= mag(din.b_den);
    end
    if (cmd.mul) begin
      case (op)
        OP_MUL: begin
          p1 <= MW'(anm) * MW'(bnm); p2 <= '0; p3 <= MW'(adm) * MW'(bdm);
        end
        OP_DIV: begin
          p1 <= MW'(anm) * MW'(bdm); p2 <= '0; p3 <= MW'(adm) * MW'(bnm);
        end
        default: begin
          p1 <= MW'(anm) * MW'(bdm); p2 <= MW'(bnm) * MW'(adm);
          p3 <= MW'(adm) * MW'(bdm);
        end
      endcase
    end
    if (cmd.comb) begin
      neg <= neg_c; num <= num_c; den <= den_c;
      x   <= num_c; y   <= den_c;
    end
    // x mod y, bit-serial
    if (cmd.mstart) begin
      phase <= 1'b0; dvd <= x; rem <= '0; quo <= '0; cnt <= CW'(MW);
    end
    if (cmd.gnext) begin
      x <= y; y <= rem;
    end
    if (cmd.dstart) begin
      // x holds the gcd; divide num first
      phase <= 1'b1; dvd <= num; rem <= '0; quo <= '0; cnt <= CW'(MW);
    end
    if (cmd.dnext) begin
      qn <= quo; dvd <= den; rem <= '0; quo <= '0; cnt <= CW'(MW);
    end
    if (cmd.step) begin
      dvd <= dvd << 1;
      if (!trial[MW]) rem <= trial[MW-1:0];
      else rem <= {rem[MW-2:0], dvd[MW-1]};
      quo <= {quo[MW-2:0], !trial[MW]};
      cnt <= cnt - 1'b1;
    end
    if (cmd.fin) begin
      if (err_z) begin
        dout <= '{res_num: '0, res_den: '0, status: ST_ZERODEN};
      end else if (err_d) begin
        dout <= '{res_num: '0, res_den: '0, status: ST_DIVZERO};
      end else if (num == '0) begin
        dout <= '{res_num: '0, res_den: 31'd1, status: ST_OK};
      end else begin
        dout.status  <= ST_OK;
        dout.res_den <= (quo > MW'(32'h7FFFFFFF)) ? 31'h7FFFFFFF : quo[30:0];
        if (neg) dout.res_num <= (qn > MW'(33'h80000000)) ? 32'h80000000
                                 : 32'(-qn);
        else dout.res_num <= (qn > MW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : qn[31:0];
      end
    end
  end

  assign sts.err      = err_z || err_d;
  assign sts.num_zero = (num == '0);
  assign sts.y_zero   = (y == '0);
  assign sts.cnt_zero = (cnt == '0);
endmodule

### sv/rar_ctrl.sv
// rar_ctrl: sequencer for load, multiply, gcd loop, two divisions, output
// depends on rar_pkg
module rar_ctrl import rar_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_COMB = 4'd2, S_CHK = 4'd3,
    S_GCD = 4'd4, S_MOD = 4'd5, S_DIVN = 4'd6, S_DIVD = 4'd7, S_FIN = 4'd8,
    S_OUT = 4'd9;
  logic [3:0] state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_next = S_MUL; end
      S_MUL:  begin cmd.mul = 1'b1; state_next = S_COMB; end
      S_COMB: begin cmd.comb = 1'b1; state_next = S_CHK; end
      S_CHK:  state_next = (sts.err || sts.num_zero) ? S_FIN : S_GCD;
      S_GCD: begin
        if (sts.y_zero) begin cmd.dstart = 1'b1; state_next = S_DIVN; end
        else begin cmd.mstart = 1'b1; state_next = S_MOD; end
      end
      S_MOD: begin
        if (sts.cnt_zero) begin cmd.gnext = 1'b1; state_next = S_GCD; end
        else cmd.step = 1'b1;
      end
      S_DIVN: begin
        if (sts.cnt_zero) begin cmd.dnext = 1'b1; state_next = S_DIVD; end
        else cmd.step = 1'b1;
      end
      S_DIVD: begin
        if (sts.cnt_zero) state_next = S_FIN;
        else cmd.step = 1'b1;
      end
      S_FIN:  begin cmd.fin = 1'b1; state_next = S_OUT; end
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready and valid together");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> out_valid) else $error("no result after finish");
`endif
endmodule
